### rtl/hmtp_pkg.sv
// Shared types and constants for the height map text point parser.
package hmtp_pkg;

  localparam int unsigned MaxColumns = 1024;
  localparam int unsigned MaxRows    = 1024;

  localparam logic [15:0] SpacingMin   = 16'd384;
  localparam logic [15:0] HeightMagMax = 16'd32768;
  localparam logic [15:0] HeightPosMax = 16'd32767;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_SPACING = 2'd2;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SIGN    = 3'd1,
    PH_DIGITS  = 3'd2,
    PH_NUMSKIP = 3'd3,
    PH_COMMA   = 3'd4,
    PH_ZERO    = 3'd5,
    PH_HEX     = 3'd6,
    PH_TAIL    = 3'd7
  } phase_t;

  // Effective (clamped) configuration and values derived from it.
  typedef struct packed {
    logic [10:0] cols;
    logic [10:0] rows;
    logic [15:0] spacing;
    logic [9:0]  half_cols;
    logic [9:0]  half_rows;
    logic [20:0] grid_size;
  } cfg_t;

  // One finished token placed on the grid.
  typedef struct packed {
    logic [19:0]        number;
    logic [9:0]         column;
    logic [21:0]        row;
    logic signed [16:0] height;
    logic [31:0]        color;
    logic               final_pt;
  } tok_t;

endpackage

### rtl/hmtp_cfg.sv
// Configuration registers with clamped and derived grid values.
module hmtp_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               write_enable,
  input  logic [1:0]         reg_index,
  input  logic [15:0]        write_data,
  output hmtp_pkg::cfg_t     cfg
);

  logic [10:0] columns_in_use, columns_in_use_next;
  logic [10:0] rows_in_use, rows_in_use_next;
  logic [15:0] point_spacing, point_spacing_next;
  logic [10:0] cols_c;
  logic [10:0] rows_c;
  logic [15:0] sp_c;
  logic [21:0] size_c;

  always_comb begin
    columns_in_use_next = columns_in_use;
    rows_in_use_next    = rows_in_use;
    point_spacing_next  = point_spacing;
    if (write_enable) begin
      unique case (reg_index)
        hmtp_pkg::REG_COLUMNS: columns_in_use_next = write_data[10:0];
        hmtp_pkg::REG_ROWS:    rows_in_use_next    = write_data[10:0];
        hmtp_pkg::REG_SPACING: point_spacing_next  = write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= 11'd1;
      rows_in_use    <= 11'd1;
      point_spacing  <= hmtp_pkg::SpacingMin;
    end else begin
      columns_in_use <= columns_in_use_next;
      rows_in_use    <= rows_in_use_next;
      point_spacing  <= point_spacing_next;
    end
  end

  always_comb begin
    if (columns_in_use_next == 11'd0) begin
      cols_c = 11'd1;
    end else if (columns_in_use_next > 11'(hmtp_pkg::MaxColumns)) begin
      cols_c = 11'(hmtp_pkg::MaxColumns);
    end else begin
      cols_c = columns_in_use_next;
    end
    if (rows_in_use_next == 11'd0) begin
      rows_c = 11'd1;
    end else if (rows_in_use_next > 11'(hmtp_pkg::MaxRows)) begin
      rows_c = 11'(hmtp_pkg::MaxRows);
    end else begin
      rows_c = rows_in_use_next;
    end
    sp_c   = (point_spacing_next < hmtp_pkg::SpacingMin) ? hmtp_pkg::SpacingMin :
             point_spacing_next;
    size_c = {11'd0, cols_c} * {11'd0, rows_c};
  end

  // Derived values load on the same edge as the write, so a write takes effect at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cols      <= 11'd1;
      cfg.rows      <= 11'd1;
      cfg.spacing   <= hmtp_pkg::SpacingMin;
      cfg.half_cols <= 10'd0;
      cfg.half_rows <= 10'd0;
      cfg.grid_size <= 21'd1;
    end else begin
      cfg.cols      <= cols_c;
      cfg.rows      <= rows_c;
      cfg.spacing   <= sp_c;
      cfg.half_cols <= cols_c[10:1];
      cfg.half_rows <= rows_c[10:1];
      cfg.grid_size <= size_c[20:0];
    end
  end

endmodule

### rtl/hmtp_parse.sv
// Character parser, grid position counters and the finished token register.
module hmtp_parse (
  input  logic               clk,
  input  logic               rst,
  input  hmtp_pkg::cfg_t     cfg,
  input  logic               accept,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  input  logic               take,
  output logic               tok_valid,
  output hmtp_pkg::tok_t     tok
);

  hmtp_pkg::phase_t phase, phase_next;
  logic [15:0] height_accum, height_accum_next;
  logic        height_negative, height_negative_next;
  logic [31:0] color_accum, color_accum_next;
  logic [9:0]  column_count, column_count_next;
  logic [21:0] row_count, row_count_next;
  logic [20:0] points_done, points_done_next;

  logic        is_digit, is_alpha, is_hex, ended, finish, emit;
  logic [3:0]  digit_val, hex_val;
  logic [19:0] acc_times_ten;
  hmtp_pkg::phase_t ph_byte, ph_start;
  logic [15:0] acc_byte, acc_start;
  logic        neg_byte, neg_start;
  logic [31:0] color_byte;
  logic [15:0] fin_acc;
  logic        fin_neg;
  logic [31:0] fin_color;
  logic signed [16:0] fin_height;
  logic        wrap_pre, wrap_post;
  logic [9:0]  col_pre;
  logic [21:0] row_pre, row_post;
  logic [10:0] col_inc;

  always_comb begin
    is_digit  = (text_byte >= 8'h30) && (text_byte <= 8'h39);
    is_alpha  = ((text_byte >= 8'h61) && (text_byte <= 8'h7a)) ||
                ((text_byte >= 8'h41) && (text_byte <= 8'h5a));
    digit_val = text_byte[3:0];
    is_hex    = 1'b1;
    hex_val   = digit_val;
    if (is_digit) begin
      hex_val = digit_val;
    end else if ((text_byte >= 8'h61) && (text_byte <= 8'h66)) begin
      hex_val = 4'(text_byte - 8'h57);
    end else if ((text_byte >= 8'h41) && (text_byte <= 8'h46)) begin
      hex_val = 4'(text_byte - 8'h37);
    end else begin
      is_hex = 1'b0;
    end

    // Start of a token as seen from the space between tokens.
    ph_start  = hmtp_pkg::PH_IDLE;
    acc_start = 16'd0;
    neg_start = 1'b0;
    if (text_byte == hmtp_pkg::CH_MINUS) begin
      ph_start  = hmtp_pkg::PH_SIGN;
      neg_start = 1'b1;
    end else if (is_digit) begin
      ph_start  = hmtp_pkg::PH_DIGITS;
      acc_start = {12'd0, digit_val};
    end else if (is_alpha) begin
      ph_start  = hmtp_pkg::PH_TAIL;
    end

    acc_times_ten = {1'b0, height_accum, 3'b000} + {3'b000, height_accum, 1'b0}
                    + {16'd0, digit_val};

    ph_byte    = phase;
    acc_byte   = height_accum;
    neg_byte   = height_negative;
    color_byte = color_accum;
    ended      = 1'b0;
    case (phase)
      hmtp_pkg::PH_SIGN, hmtp_pkg::PH_DIGITS, hmtp_pkg::PH_NUMSKIP: begin
        if (is_digit) begin
          if (phase != hmtp_pkg::PH_NUMSKIP) begin
            acc_byte = (acc_times_ten > {4'd0, hmtp_pkg::HeightMagMax}) ?
                       hmtp_pkg::HeightMagMax : acc_times_ten[15:0];
            ph_byte  = hmtp_pkg::PH_DIGITS;
          end
        end else if (text_byte == hmtp_pkg::CH_MINUS) begin
          ph_byte = hmtp_pkg::PH_NUMSKIP;
        end else if (text_byte == hmtp_pkg::CH_COMMA) begin
          ph_byte = hmtp_pkg::PH_COMMA;
        end else if (is_alpha) begin
          ph_byte = hmtp_pkg::PH_TAIL;
        end else begin
          ended = 1'b1;
        end
      end
      hmtp_pkg::PH_COMMA: begin
        if (text_byte == hmtp_pkg::CH_ZERO) begin
          ph_byte = hmtp_pkg::PH_ZERO;
        end else begin
          ended = 1'b1;
        end
      end
      hmtp_pkg::PH_ZERO: ph_byte = hmtp_pkg::PH_HEX;
      hmtp_pkg::PH_HEX: begin
        if (is_hex) begin
          color_byte = {color_accum[27:0], hex_val};
        end else if (is_alpha) begin
          ph_byte = hmtp_pkg::PH_TAIL;
        end else begin
          ended = 1'b1;
        end
      end
      hmtp_pkg::PH_TAIL: begin
        if (!is_alpha && !is_digit) begin
          ended = 1'b1;
        end
      end
      default: begin
        ph_byte    = ph_start;
        acc_byte   = acc_start;
        neg_byte   = neg_start;
        color_byte = 32'd0;
      end
    endcase

    // A byte that ends a token is taken again as lying between tokens.
    if (ended) begin
      ph_byte    = ph_start;
      acc_byte   = acc_start;
      neg_byte   = neg_start;
      color_byte = 32'd0;
    end

    finish = ended || (end_of_text && (ph_byte != hmtp_pkg::PH_IDLE));
    if (ended) begin
      fin_acc   = height_accum;
      fin_neg   = height_negative;
      fin_color = color_accum;
    end else begin
      fin_acc   = acc_byte;
      fin_neg   = neg_byte;
      fin_color = color_byte;
    end
    if (fin_neg) begin
      fin_height = -$signed({1'b0, fin_acc});
    end else if (fin_acc > hmtp_pkg::HeightPosMax) begin
      fin_height = $signed({1'b0, hmtp_pkg::HeightPosMax});
    end else begin
      fin_height = $signed({1'b0, fin_acc});
    end

    if (end_of_text) begin
      phase_next           = hmtp_pkg::PH_IDLE;
      height_accum_next    = 16'd0;
      height_negative_next = 1'b0;
      color_accum_next     = 32'd0;
    end else begin
      phase_next           = ph_byte;
      height_accum_next    = acc_byte;
      height_negative_next = neg_byte;
      color_accum_next     = color_byte;
    end

    // Grid placement: wrap before the point if the column count shrank.
    emit      = finish && (points_done < cfg.grid_size);
    wrap_pre  = {1'b0, column_count} >= cfg.cols;
    col_pre   = wrap_pre ? 10'd0 : column_count;
    row_pre   = wrap_pre ? row_count + 22'd1 : row_count;
    col_inc   = {1'b0, col_pre} + 11'd1;
    wrap_post = col_inc >= cfg.cols;
    row_post  = wrap_post ? row_pre + 22'd1 : row_pre;

    column_count_next = column_count;
    row_count_next    = row_count;
    points_done_next  = points_done;
    if (emit) begin
      column_count_next = wrap_post ? 10'd0 : col_inc[9:0];
      row_count_next    = row_post;
      points_done_next  = points_done + 21'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= hmtp_pkg::PH_IDLE;
      height_accum    <= 16'd0;
      height_negative <= 1'b0;
      color_accum     <= 32'd0;
      column_count    <= 10'd0;
      row_count       <= 22'd0;
      points_done     <= 21'd0;
    end else if (accept) begin
      phase           <= phase_next;
      height_accum    <= height_accum_next;
      height_negative <= height_negative_next;
      color_accum     <= color_accum_next;
      column_count    <= column_count_next;
      row_count       <= row_count_next;
      points_done     <= points_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (accept) begin
      tok_valid <= emit;
    end else if (take) begin
      tok_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      tok.number   <= points_done[19:0];
      tok.column   <= col_pre;
      tok.row      <= row_pre;
      tok.height   <= fin_height;
      tok.color    <= fin_color;
      tok.final_pt <= (points_done == cfg.grid_size - 21'd1);
    end
  end

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_text |=> (phase == hmtp_pkg::PH_IDLE) && (height_accum == 16'd0))
    else $error("parser not idle after end of text");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept && emit |=> points_done == $past(points_done) + 21'd1)
    else $error("point count did not advance on emission");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !(accept && emit) |=> $stable(points_done))
    else $error("point count changed without an emission");

endmodule

### rtl/hmtp_point.sv
// Coordinate scaling by the point spacing and the result register.
module hmtp_point (
  input  logic               clk,
  input  logic               rst,
  input  hmtp_pkg::cfg_t     cfg,
  input  logic               tok_valid,
  input  hmtp_pkg::tok_t     tok,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [19:0]        point_number,
  output logic signed [31:0] x_pos,
  output logic signed [31:0] y_pos,
  output logic signed [31:0] z_pos,
  output logic [31:0]        point_color,
  output logic               final_point
);

  logic signed [16:0] sp_s;
  logic signed [11:0] x_diff;
  logic signed [22:0] y_diff;
  logic signed [28:0] x_prod;
  logic signed [39:0] y_prod;
  logic signed [33:0] z_prod;

  assign take = tok_valid && (!out_valid || !out_stall);

  always_comb begin
    sp_s   = $signed({1'b0, cfg.spacing});
    x_diff = $signed({2'b00, tok.column}) - $signed({2'b00, cfg.half_cols});
    y_diff = $signed({1'b0, tok.row}) - $signed({13'd0, cfg.half_rows});
    x_prod = x_diff * sp_s;
    y_prod = y_diff * sp_s;
    z_prod = tok.height * sp_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      point_number <= tok.number;
      x_pos        <= {{3{x_prod[28]}}, x_prod};
      y_pos        <= y_prod[31:0];
      z_pos        <= z_prod[31:0];
      point_color  <= tok.color;
      final_point  <= tok.final_pt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !take)
    else $error("result overwritten while stalled");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("taken token did not reach the result register");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    !tok_valid && !out_stall |=> !out_valid)
    else $error("result repeated");

endmodule

### rtl/height_map_text_point_parser_core.sv
// Top level of the height map text point parser.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  text_byte, end_of_text
//   result    out        out_valid/out_stall  point_number, x_pos, y_pos, z_pos,
//                                             point_color, final_point
//   config    in         write_enable         reg_index, write_data
//
// One byte is taken every clock while in_stall is low; a finished token is held
// in the token register, then the spacing multipliers feed the result register.
// The three small multipliers in the point stage set the longest path.
// Reset is synchronous and clears the parser, the grid counters and both valids.
// A stalled result holds; one token can wait behind it before in_stall rises.
module height_map_text_point_parser_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [19:0]        point_number,
  output logic signed [31:0] x_pos,
  output logic signed [31:0] y_pos,
  output logic signed [31:0] z_pos,
  output logic [31:0]        point_color,
  output logic               final_point,
  input  logic               write_enable,
  input  logic [1:0]         reg_index,
  input  logic [15:0]        write_data
);

  hmtp_pkg::cfg_t cfg;
  hmtp_pkg::tok_t tok;
  logic           tok_valid;
  logic           take;
  logic           accept;

  assign in_stall = tok_valid && !take;
  assign accept   = in_valid && !in_stall;

  hmtp_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  hmtp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .take        (take),
    .tok_valid   (tok_valid),
    .tok         (tok)
  );

  hmtp_point u_point (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .tok_valid    (tok_valid),
    .tok          (tok),
    .take         (take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_number (point_number),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .z_pos        (z_pos),
    .point_color  (point_color),
    .final_point  (final_point)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> tok_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

endmodule
